// ----- rtl/additive_pulse_wave_synth_defines.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the pulse wave synthesiser
// clocked on clk_i, switched off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ADDITIVE_PULSE_WAVE_SYNTH_DEFINES_SVH
`define ADDITIVE_PULSE_WAVE_SYNTH_DEFINES_SVH

// same-cycle implication
`define APWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define APWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/apws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apws_pkg
// constants, tables, microcode and types of the pulse wave synthesiser
// ----------------------------------------------------------------------------
package apws_pkg;

  // sizing
  localparam int MAX_ORDER       = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QTAB_N          = 1 << SINE_TABLE_BITS;
  localparam int QADDR_W         = SINE_TABLE_BITS + 1;
  localparam int KW              = $clog2(MAX_ORDER + 1);
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  // fixed-point constants
  localparam logic [31:0]        HALF_PI_Q30     = 32'd1686629713;
  localparam logic signed [32:0] TWO_OVER_PI_Q30 = 33'sd683565276;
  localparam logic [31:0]        QUARTER_TURN    = 32'h4000_0000;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP   = 3'd0,
    CFG_PHASE_OFFSET = 3'd1,
    CFG_DUTY_CYCLE   = 3'd2,
    CFG_HARM_COUNT   = 3'd3,
    CFG_AMPLITUDE    = 3'd4,
    CFG_NORM_GAIN    = 3'd5
  } cfg_idx_e;

  // reciprocal table, round(2^16 / k), k = 0..64
  localparam logic [16:0] RECIP_ALL [65] = '{
    17'd0,     17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10923,
    17'd9362,  17'd8192,  17'd7282,  17'd6554,  17'd5958,  17'd5461,  17'd5041,
    17'd4681,  17'd4369,  17'd4096,  17'd3855,  17'd3641,  17'd3449,  17'd3277,
    17'd3121,  17'd2979,  17'd2849,  17'd2731,  17'd2621,  17'd2521,  17'd2427,
    17'd2341,  17'd2260,  17'd2185,  17'd2114,  17'd2048,  17'd1986,  17'd1928,
    17'd1872,  17'd1820,  17'd1771,  17'd1725,  17'd1680,  17'd1638,  17'd1598,
    17'd1560,  17'd1524,  17'd1489,  17'd1456,  17'd1425,  17'd1394,  17'd1365,
    17'd1337,  17'd1311,  17'd1285,  17'd1260,  17'd1237,  17'd1214,  17'd1192,
    17'd1170,  17'd1150,  17'd1130,  17'd1111,  17'd1092,  17'd1074,  17'd1057,
    17'd1040,  17'd1024
  };

  // taylor series divisors (2n)(2n+1)
  localparam int SIN_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  typedef logic [15:0] qtab_t [QTAB_N+1];

  // quarter-wave sine table, worked out at elaboration
  function automatic qtab_t build_qtab();
    qtab_t              t;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    int                 i;
    int                 n;
    for (i = 0; i <= QTAB_N; i++) begin
      x    = (64'(HALF_PI_Q30) * 64'(i)) / QTAB_N;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / SIN_DIV[n-1];
        if (n % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32768) begin
        sum = 64'sd32768;
      end
      t[i] = 16'(sum);
    end
    return t;
  endfunction

  // microcode steps
  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_INIT  = 4'd1,
    ST_LOOK  = 4'd2,
    ST_MUL1  = 4'd3,
    ST_MUL2  = 4'd4,
    ST_ACC   = 4'd5,
    ST_POST1 = 4'd6,
    ST_POST2 = 4'd7,
    ST_POST3 = 4'd8,
    ST_POST4 = 4'd9,
    ST_FIN   = 4'd10
  } step_e;

  // jump conditions
  typedef enum logic [2:0] {
    CND_NONE     = 3'd0,
    CND_NO_INPUT = 3'd1,
    CND_NO_HARM  = 3'd2,
    CND_MORE     = 3'd3,
    CND_OUT_BUSY = 3'd4
  } cond_e;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_IDX_STEP = 3'd0,
    MUL_SIN_COS  = 3'd1,
    MUL_RECIP    = 3'd2,
    MUL_AMP_GAIN = 3'd3,
    MUL_TWO_PI   = 3'd4,
    MUL_LEVEL    = 3'd5
  } mul_sel_e;

  typedef struct packed {
    logic     in_rdy;
    logic     init_ld;
    logic     phase_ld;
    logic     rom_rd;
    logic     phase_adv;
    logic     prod_en;
    mul_sel_e mul_sel;
    logic     acc_add;
    logic     y1_ld;
    logic     ag_ld;
    logic     y3_ld;
    logic     out_ld;
    cond_e    cond;
    step_e    jump;
    step_e    next;
  } uc_word_t;

  // control store
  function automatic uc_word_t uc_rom(step_e s);
    uc_word_t w;
    w = '{mul_sel: MUL_IDX_STEP, cond: CND_NONE, jump: ST_IDLE, next: ST_IDLE,
          default: 1'b0};
    unique case (s)
      ST_IDLE: begin
        w.in_rdy  = 1'b1;
        w.init_ld = 1'b1;
        w.prod_en = 1'b1;
        w.mul_sel = MUL_IDX_STEP;
        w.cond    = CND_NO_INPUT;
        w.jump    = ST_IDLE;
        w.next    = ST_INIT;
      end
      ST_INIT: begin
        w.phase_ld = 1'b1;
        w.cond     = CND_NO_HARM;
        w.jump     = ST_POST1;
        w.next     = ST_LOOK;
      end
      ST_LOOK: begin
        w.rom_rd    = 1'b1;
        w.phase_adv = 1'b1;
        w.next      = ST_MUL1;
      end
      ST_MUL1: begin
        w.prod_en = 1'b1;
        w.mul_sel = MUL_SIN_COS;
        w.next    = ST_MUL2;
      end
      ST_MUL2: begin
        w.prod_en = 1'b1;
        w.mul_sel = MUL_RECIP;
        w.next    = ST_ACC;
      end
      ST_ACC: begin
        w.acc_add = 1'b1;
        w.cond    = CND_MORE;
        w.jump    = ST_LOOK;
        w.next    = ST_POST1;
      end
      ST_POST1: begin
        w.y1_ld   = 1'b1;
        w.prod_en = 1'b1;
        w.mul_sel = MUL_AMP_GAIN;
        w.next    = ST_POST2;
      end
      ST_POST2: begin
        w.ag_ld   = 1'b1;
        w.prod_en = 1'b1;
        w.mul_sel = MUL_TWO_PI;
        w.next    = ST_POST3;
      end
      ST_POST3: begin
        w.y3_ld = 1'b1;
        w.next  = ST_POST4;
      end
      ST_POST4: begin
        w.prod_en = 1'b1;
        w.mul_sel = MUL_LEVEL;
        w.next    = ST_FIN;
      end
      ST_FIN: begin
        w.out_ld = 1'b1;
        w.cond   = CND_OUT_BUSY;
        w.jump   = ST_FIN;
        w.next   = ST_IDLE;
      end
      default: begin
        w.next = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/apws_sine_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apws_sine_rom
// two-port quarter-wave sine rom, registered read, full-turn phase in,
// signed q2.15 out
// ----------------------------------------------------------------------------
module apws_sine_rom
  import apws_pkg::*;
(
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  logic [31:0]        phase_a_i,
  input  logic [31:0]        phase_b_i,
  output logic signed [16:0] sin_a_o,
  output logic signed [16:0] sin_b_o
);

  localparam qtab_t QTAB = build_qtab();

  logic [QADDR_W-1:0] addr_a;
  logic [QADDR_W-1:0] addr_b;
  logic [15:0]        mag_a_q;
  logic [15:0]        mag_b_q;
  logic               neg_a_q;
  logic               neg_b_q;

  // fold odd quadrants back onto the table
  always_comb begin
    addr_a = QADDR_W'(phase_a_i[29 -: SINE_TABLE_BITS]);
    addr_b = QADDR_W'(phase_b_i[29 -: SINE_TABLE_BITS]);
    if (phase_a_i[30]) begin
      addr_a = QADDR_W'(QTAB_N) - addr_a;
    end
    if (phase_b_i[30]) begin
      addr_b = QADDR_W'(QTAB_N) - addr_b;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mag_a_q <= QTAB[addr_a];
      mag_b_q <= QTAB[addr_b];
      neg_a_q <= phase_a_i[31];
      neg_b_q <= phase_b_i[31];
    end
  end

  // sign from the upper half turn
  assign sin_a_o = neg_a_q ? -$signed({1'b0, mag_a_q}) : $signed({1'b0, mag_a_q});
  assign sin_b_o = neg_b_q ? -$signed({1'b0, mag_b_q}) : $signed({1'b0, mag_b_q});

endmodule

// ----- rtl/additive_pulse_wave_synth.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// additive_pulse_wave_synth
// band-limited pulse wave from a fourier sum, one sample per item
// ----------------------------------------------------------------------------
//   channel   direction  handshake                  payload
//   in        sink       in_valid_i / in_ready_o    sample_index_i [31:0]
//   out       source     out_valid_o / out_ready_i  sample_value_o [15:0] signed
//   cfg       sink       cfg_we_i                   cfg_idx_i, cfg_data_i
//
// an item sums K harmonics, K = harmonic count clamped to MAX_ORDER: each
// harmonic is four microcode steps around the one shared 33x33 multiplier
// ready straight out of reset, no clearing pass
// the result waits in the output register; new items are taken meanwhile and
// the sequencer holds in its last step only if that register is still full
// ----------------------------------------------------------------------------
`include "additive_pulse_wave_synth_defines.svh"

module additive_pulse_wave_synth
  import apws_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [31:0]           sample_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [15:0]    sample_value_o
);

  // configuration registers
  logic [31:0] phase_step_q;
  logic [31:0] phase_offset_q;
  logic [15:0] duty_cycle_q;
  logic [5:0]  harm_count_q;
  logic [14:0] amplitude_q;
  logic [15:0] norm_gain_q;

  // sequencer
  step_e    step_q, step_d;
  uc_word_t uc;
  logic     take;
  logic     out_free;

  // datapath
  logic [KW-1:0]       k_q;
  logic [KW-1:0]       count_q;
  logic [KW-1:0]       count_d;
  logic [31:0]         w_q;
  logic [31:0]         sp_q;
  logic [31:0]         cp_q;
  logic signed [51:0]  acc_q;
  logic signed [65:0]  prod_q;
  logic signed [31:0]  y1_q;
  logic signed [31:0]  y3_q;
  logic [30:0]         ag_q;
  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [65:0]  mul_p;
  logic signed [16:0]  sin_s;
  logic signed [16:0]  sin_c;
  logic signed [51:0]  y1_sum;
  logic signed [65:0]  y2_sum;
  logic signed [65:0]  r_sum;
  logic signed [15:0]  r_sat;
  logic                out_valid_q;
  logic signed [15:0]  sample_value_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= 32'd137013;
      phase_offset_q <= 32'd0;
      duty_cycle_q   <= 16'd13107;
      harm_count_q   <= 6'd10;
      amplitude_q    <= 15'd16384;
      norm_gain_q    <= 16'd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PHASE_STEP:   phase_step_q   <= cfg_data_i;
        CFG_PHASE_OFFSET: phase_offset_q <= cfg_data_i;
        CFG_DUTY_CYCLE:   duty_cycle_q   <= cfg_data_i[15:0];
        CFG_HARM_COUNT:   harm_count_q   <= cfg_data_i[5:0];
        CFG_AMPLITUDE:    amplitude_q    <= cfg_data_i[14:0];
        CFG_NORM_GAIN:    norm_gain_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // control word, jump decision
  always_comb begin
    uc       = uc_rom(step_q);
    out_free = !out_valid_q || out_ready_i;
    unique case (uc.cond)
      CND_NONE:     take = 1'b0;
      CND_NO_INPUT: take = !in_valid_i;
      CND_NO_HARM:  take = (count_q == '0);
      CND_MORE:     take = (k_q != count_q);
      CND_OUT_BUSY: take = !out_free;
      default:      take = 1'b0;
    endcase
    step_d = take ? uc.jump : uc.next;
  end

  assign in_ready_o = uc.in_rdy;

  // harmonic count clamped to MAX_ORDER
  assign count_d = ({1'b0, harm_count_q} > 7'(MAX_ORDER)) ? KW'(MAX_ORDER)
                                                          : KW'(harm_count_q);

  apws_sine_rom u_sine_rom (
    .clk_i     (clk_i),
    .rd_en_i   (uc.rom_rd),
    .phase_a_i (sp_q),
    .phase_b_i (cp_q + QUARTER_TURN),
    .sin_a_o   (sin_s),
    .sin_b_o   (sin_c)
  );

  // shared multiplier operand select
  always_comb begin
    unique case (uc.mul_sel)
      MUL_IDX_STEP: begin
        mul_a = $signed({1'b0, sample_index_i});
        mul_b = $signed({1'b0, phase_step_q});
      end
      MUL_SIN_COS: begin
        mul_a = 33'(sin_s);
        mul_b = 33'(sin_c);
      end
      MUL_RECIP: begin
        mul_a = $signed(prod_q[32:0]);
        mul_b = $signed({16'd0, RECIP_ALL[7'(k_q)]});
      end
      MUL_AMP_GAIN: begin
        mul_a = $signed({18'd0, amplitude_q});
        mul_b = $signed({17'd0, norm_gain_q});
      end
      MUL_TWO_PI: begin
        mul_a = 33'(y1_q);
        mul_b = TWO_OVER_PI_Q30;
      end
      MUL_LEVEL: begin
        mul_a = 33'(y3_q);
        mul_b = $signed({2'd0, ag_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // rounding and saturation
  always_comb begin
    y1_sum = (acc_q + (52'sd1 <<< 21)) >>> 22;
    y2_sum = (prod_q + (66'sd1 <<< 29)) >>> 30;
    r_sum  = (prod_q + (66'sd1 <<< 37)) >>> 38;
    if (r_sum > 66'sd32767) begin
      r_sat = 16'sh7fff;
    end else if (r_sum < -66'sd32768) begin
      r_sat = -16'sh8000;
    end else begin
      r_sat = 16'(r_sum);
    end
  end

  // loop control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= KW'(1);
      count_q <= '0;
    end else if (uc.init_ld) begin
      k_q     <= KW'(1);
      count_q <= count_d;
    end else if (uc.acc_add) begin
      k_q <= k_q + KW'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (uc.init_ld) begin
      acc_q <= '0;
      sp_q  <= {1'b0, duty_cycle_q, 15'd0};
    end
    if (uc.phase_ld) begin
      w_q  <= prod_q[31:0];
      cp_q <= prod_q[31:0] + phase_offset_q;
    end
    if (uc.phase_adv) begin
      sp_q <= sp_q + {1'b0, duty_cycle_q, 15'd0};
      cp_q <= cp_q + w_q;
    end
    if (uc.prod_en) begin
      prod_q <= mul_p;
    end
    if (uc.acc_add) begin
      acc_q <= acc_q + 52'(prod_q);
    end
    if (uc.y1_ld) begin
      y1_q <= 32'(y1_sum);
    end
    if (uc.ag_ld) begin
      ag_q <= prod_q[30:0];
    end
    if (uc.y3_ld) begin
      y3_q <= 32'(y2_sum) + $signed({8'd0, duty_cycle_q, 8'd0});
    end
    if (uc.out_ld && out_free) begin
      sample_value_q <= r_sat;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uc.out_ld && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = sample_value_q;

  // checks
  `APWS_ASSERT_NXT(a_accept_starts, in_valid_i && in_ready_o, step_q == ST_INIT, "no start")
  `APWS_ASSERT_IMP(a_harm_range, step_q == ST_LOOK, k_q != '0 && k_q <= count_q, "k out of range")
  `APWS_ASSERT_NXT(a_out_source, (step_q != ST_FIN) && !out_valid_o, !out_valid_o, "stray result")

endmodule
